/* src/qsm_pkg.sv */
package qsm_pkg;

  // counter and fixed-point sizing
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned FRAC_BITS   = 4;

  // register and field widths
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned ELAPSED_W   = 16;
  localparam int unsigned SPEED_W     = 24;
  localparam int unsigned WIN_COUNT_W = 16;

  // speed = mag * SCALE / (cpr * elapsed)
  localparam int unsigned MS_PER_MIN = 60000;
  localparam int unsigned SCALE      = MS_PER_MIN * (1 << FRAC_BITS);
  localparam int unsigned SCALE_W    = $clog2(SCALE + 1);
  localparam int unsigned NUM_W      = COUNT_WIDTH + SCALE_W;
  localparam int unsigned DEN_W      = CFG_W + ELAPSED_W;
  localparam int unsigned STEP_W     = $clog2(NUM_W);

  // queue between decoder and divider
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0]     CPR_RESET    = CFG_W'(3960);
  localparam logic [CFG_W-1:0]     WINDOW_RESET = CFG_W'(50);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;

  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  localparam logic [SPEED_W-1:0] SPEED_POS_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] SPEED_NEG_MAG = {1'b1, {(SPEED_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPR    = 1'b0,
    REG_WINDOW = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // one finished window handed to the divider
  typedef struct packed {
    logic signed [COUNT_WIDTH-1:0] count;
    logic [ELAPSED_W-1:0]          elapsed;
    logic                          error;
    logic [CFG_W-1:0]              cpr;
  } job_t;

endpackage

/* src/quadrature_speed_meter.sv */
// path: a window result passes from the sample that closes the window through the window
//   queue and the IDLE, MUL, DIV and DONE states, DIV being the bit-per-cycle restoring divider
// throughput: one sample per cycle; in_stall_o rises only while the two-entry window
//   queue is full, i.e. when windows close faster than one per divide
// reset: asynchronous, active low; clears phases, count, elapsed time, error flag, queue
//   and output valid; counts_per_rev returns to 3960 and window_ms to 50
module quadrature_speed_meter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [qsm_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [qsm_pkg::CFG_W-1:0]              cfg_data_i,
  // sample channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   phase_a_i,
  input  logic                                   phase_b_i,
  input  logic                                   ms_tick_i,
  // window result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [qsm_pkg::SPEED_W-1:0]     speed_rpm_q4_o,
  output logic signed [qsm_pkg::WIN_COUNT_W-1:0] window_count_o,
  output logic [qsm_pkg::ELAPSED_W-1:0]          window_length_o,
  output logic                                   phase_error_o
);

  // configuration registers
  logic [qsm_pkg::CFG_W-1:0] cpr_q, win_q;

  // queue handshake
  logic          push, pop, full, empty, accept;
  qsm_pkg::job_t push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= qsm_pkg::CPR_RESET;
      win_q <= qsm_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      unique case (qsm_pkg::cfg_reg_e'(cfg_idx_i))
        qsm_pkg::REG_CPR:    cpr_q <= cfg_data_i;
        qsm_pkg::REG_WINDOW: win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stall samples only when no room for a closing window
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // front: decode phases, keep count and elapsed time, close windows
  qsm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .phase_a_i        (phase_a_i),
    .phase_b_i        (phase_b_i),
    .ms_tick_i        (ms_tick_i),
    .counts_per_rev_i (cpr_q),
    .window_ms_i      (win_q),
    .push_o           (push),
    .job_o            (push_job)
  );

  // finished windows wait here for the divider
  qsm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .full_o      (full),
    .empty_o     (empty)
  );

  // back: scale, divide, saturate and hold the result for transfer
  qsm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_rpm_q4_o  (speed_rpm_q4_o),
    .window_count_o  (window_count_o),
    .window_length_o (window_length_o),
    .phase_error_o   (phase_error_o)
  );

endmodule

/* src/qsm_fifo.sv */
module qsm_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qsm_pkg::job_t   push_data_i,
  input  logic            pop_i,
  output qsm_pkg::job_t   head_o,
  output logic            full_o,
  output logic            empty_o
);

  qsm_pkg::job_t                   mem_q [qsm_pkg::QUEUE_DEPTH];
  logic [qsm_pkg::PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [qsm_pkg::PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [qsm_pkg::PTR_W:0]         fill_q, fill_d;
  logic                            do_push, do_pop;

  assign full_o  = (fill_q == (qsm_pkg::PTR_W + 1)'(qsm_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == qsm_pkg::PTR_W'(qsm_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == qsm_pkg::PTR_W'(qsm_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/qsm_front.sv */
module qsm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         phase_a_i,
  input  logic                         phase_b_i,
  input  logic                         ms_tick_i,
  input  logic [qsm_pkg::CFG_W-1:0]    counts_per_rev_i,
  input  logic [qsm_pkg::CFG_W-1:0]    window_ms_i,
  output logic                         push_o,
  output qsm_pkg::job_t                job_o
);

  logic                                    last_a_q, last_b_q, primed_q;
  logic signed [qsm_pkg::COUNT_WIDTH-1:0]  count_q, count_d;
  logic [qsm_pkg::ELAPSED_W-1:0]           elapsed_q, elapsed_d;
  logic                                    err_q, err_d;

  logic                                    chg_a, chg_b, step_up, step_dn;
  logic signed [qsm_pkg::COUNT_WIDTH-1:0]  count_new;
  logic                                    err_new;
  logic [qsm_pkg::ELAPSED_W-1:0]           elapsed_new;
  logic [qsm_pkg::CFG_W-1:0]               win;
  logic                                    fire;

  // x4 decode, simultaneous change is an error
  always_comb begin
    chg_a   = primed_q && (phase_a_i != last_a_q);
    chg_b   = primed_q && (phase_b_i != last_b_q);
    step_up = 1'b0;
    step_dn = 1'b0;
    if (chg_a && !chg_b) begin
      step_up = (phase_a_i == phase_b_i);
      step_dn = (phase_a_i != phase_b_i);
    end else if (chg_b && !chg_a) begin
      step_up = (phase_a_i != phase_b_i);
      step_dn = (phase_a_i == phase_b_i);
    end
  end

  always_comb begin
    count_new = count_q;
    err_new   = err_q || (chg_a && chg_b);
    if (step_up) begin
      if (count_q == qsm_pkg::COUNT_MAX) begin
        err_new = 1'b1;
      end else begin
        count_new = count_q + 1'b1;
      end
    end else if (step_dn) begin
      if (count_q == qsm_pkg::COUNT_MIN) begin
        err_new = 1'b1;
      end else begin
        count_new = count_q - 1'b1;
      end
    end
  end

  // window end: zero window behaves as one
  always_comb begin
    elapsed_new = elapsed_q;
    if (ms_tick_i && (elapsed_q != qsm_pkg::ELAPSED_MAX)) begin
      elapsed_new = elapsed_q + 1'b1;
    end
    win  = (window_ms_i == '0) ? qsm_pkg::CFG_W'(1) : window_ms_i;
    fire = ms_tick_i && (elapsed_new >= win);
  end

  always_comb begin
    push_o        = accept_i && fire;
    job_o.count   = count_new;
    job_o.elapsed = elapsed_new;
    job_o.error   = err_new;
    job_o.cpr     = counts_per_rev_i;
    count_d       = fire ? '0 : count_new;
    elapsed_d     = fire ? '0 : elapsed_new;
    err_d         = fire ? 1'b0 : err_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q  <= 1'b0;
      last_b_q  <= 1'b0;
      primed_q  <= 1'b0;
      count_q   <= '0;
      elapsed_q <= '0;
      err_q     <= 1'b0;
    end else if (accept_i) begin
      last_a_q  <= phase_a_i;
      last_b_q  <= phase_b_i;
      primed_q  <= 1'b1;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
      err_q     <= err_d;
    end
  end

endmodule

/* src/qsm_back.sv */
module qsm_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  qsm_pkg::job_t                    head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [qsm_pkg::SPEED_W-1:0]     speed_rpm_q4_o,
  output logic signed [qsm_pkg::WIN_COUNT_W-1:0] window_count_o,
  output logic [qsm_pkg::ELAPSED_W-1:0]          window_length_o,
  output logic                             phase_error_o
);

  qsm_pkg::back_state_e state_q, state_d;

  logic                                   neg_q;
  logic [qsm_pkg::COUNT_WIDTH-1:0]        mag_q;
  logic signed [qsm_pkg::COUNT_WIDTH-1:0] cnt_q;
  logic [qsm_pkg::ELAPSED_W-1:0]          el_q;
  logic                                   err_q;
  logic [qsm_pkg::CFG_W-1:0]              cpr_q;

  logic [qsm_pkg::NUM_W-1:0]   num_q;
  logic [qsm_pkg::DEN_W-1:0]   den_q;
  logic [qsm_pkg::DEN_W-1:0]   rem_q;
  logic [qsm_pkg::STEP_W-1:0]  step_q;

  logic                        out_valid_q;
  logic [qsm_pkg::SPEED_W-1:0] speed_q;
  logic signed [qsm_pkg::WIN_COUNT_W-1:0] wcount_q;
  logic [qsm_pkg::ELAPSED_W-1:0] wlen_q;
  logic                        perr_q;

  logic take, mul_en, div_en, load_out, out_free, last_step;
  logic [qsm_pkg::DEN_W:0]     rem_sh;
  logic                        ge;
  logic [qsm_pkg::DEN_W-1:0]   rem_nx;
  logic [qsm_pkg::SPEED_W-1:0] sat_mag, speed_nx;
  logic [qsm_pkg::COUNT_WIDTH-1:0] head_mag;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = (step_q == qsm_pkg::STEP_W'(qsm_pkg::NUM_W - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qsm_pkg::BK_IDLE: if (!empty_i) state_d = qsm_pkg::BK_MUL;
      qsm_pkg::BK_MUL:  state_d = qsm_pkg::BK_DIV;
      qsm_pkg::BK_DIV:  if (last_step) state_d = qsm_pkg::BK_DONE;
      qsm_pkg::BK_DONE: if (out_free) state_d = qsm_pkg::BK_IDLE;
      default:          state_d = qsm_pkg::BK_IDLE;
    endcase
  end

  // controls
  always_comb begin
    take     = 1'b0;
    mul_en   = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      qsm_pkg::BK_IDLE: take     = !empty_i;
      qsm_pkg::BK_MUL:  mul_en   = 1'b1;
      qsm_pkg::BK_DIV:  div_en   = 1'b1;
      qsm_pkg::BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  assign pop_o = take;

  // magnitude of the count, the most negative count maps cleanly
  assign head_mag = head_i.count[qsm_pkg::COUNT_WIDTH-1] ?
                    (~head_i.count + 1'b1) : head_i.count;

  // one restoring division step
  always_comb begin
    rem_sh = {rem_q, num_q[qsm_pkg::NUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    rem_nx = ge ? qsm_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                : qsm_pkg::DEN_W'(rem_sh);
  end

  // saturate and apply sign, a zero divisor gives an all-ones quotient,
  // no count gives no speed whatever the divisor
  always_comb begin
    if (mag_q == '0) begin
      sat_mag  = '0;
      speed_nx = '0;
    end else if (neg_q) begin
      sat_mag  = (num_q > qsm_pkg::NUM_W'(qsm_pkg::SPEED_NEG_MAG)) ?
                 qsm_pkg::SPEED_NEG_MAG : qsm_pkg::SPEED_W'(num_q);
      speed_nx = ~sat_mag + 1'b1;
    end else begin
      sat_mag  = (num_q > qsm_pkg::NUM_W'(qsm_pkg::SPEED_POS_MAX)) ?
                 qsm_pkg::SPEED_POS_MAX : qsm_pkg::SPEED_W'(num_q);
      speed_nx = sat_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qsm_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      neg_q <= head_i.count[qsm_pkg::COUNT_WIDTH-1];
      mag_q <= head_mag;
      cnt_q <= head_i.count;
      el_q  <= head_i.elapsed;
      err_q <= head_i.error;
      cpr_q <= head_i.cpr;
    end
    if (mul_en) begin
      num_q  <= {{qsm_pkg::SCALE_W{1'b0}}, mag_q} * qsm_pkg::NUM_W'(qsm_pkg::SCALE);
      den_q  <= {{qsm_pkg::ELAPSED_W{1'b0}}, cpr_q} * {{qsm_pkg::CFG_W{1'b0}}, el_q};
      rem_q  <= '0;
      step_q <= '0;
    end
    if (div_en) begin
      num_q  <= {num_q[qsm_pkg::NUM_W-2:0], ge};
      rem_q  <= rem_nx;
      step_q <= step_q + 1'b1;
    end
    if (load_out) begin
      speed_q  <= speed_nx;
      wcount_q <= qsm_pkg::WIN_COUNT_W'(cnt_q);
      wlen_q   <= el_q;
      perr_q   <= err_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_rpm_q4_o  = speed_q;
  assign window_count_o  = wcount_q;
  assign window_length_o = wlen_q;
  assign phase_error_o   = perr_q;

endmodule

/* src/qsm_checker.sv */
module qsm_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [qsm_pkg::SPEED_W-1:0]     speed_rpm_q4_o,
  input logic signed [qsm_pkg::WIN_COUNT_W-1:0] window_count_o,
  input logic [qsm_pkg::ELAPSED_W-1:0]          window_length_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(speed_rpm_q4_o)
      && $stable(window_count_o) && $stable(window_length_o))
    else $error("stalled result changed");

  // a window spans at least one tick
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_length_o != '0)
    else $error("zero window length");

  // no motion means no speed
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (window_count_o == '0) |-> speed_rpm_q4_o == '0)
    else $error("speed without count");

  // speed sign follows count sign
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !window_count_o[qsm_pkg::WIN_COUNT_W-1]
      |-> !speed_rpm_q4_o[qsm_pkg::SPEED_W-1])
    else $error("negative speed for forward count");

  a_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_count_o[qsm_pkg::WIN_COUNT_W-1]
      |-> speed_rpm_q4_o[qsm_pkg::SPEED_W-1] || (speed_rpm_q4_o == '0))
    else $error("positive speed for reverse count");

endmodule

bind quadrature_speed_meter qsm_checker u_qsm_checker (.*);
